// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the G.711 round-trip block.
// Depends on nothing; each macro takes its clock and active-low reset as arguments.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while reset is released.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while reset is released.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/g711rt_pkg.sv
// Package of the G.711 round-trip block: constants, stage-control type and helpers.
// Depends on nothing; used by g711rt_datapath and the top level.
package g711rt_pkg;

    localparam int unsigned CLIP_LEVEL = 32635;
    localparam int unsigned MU_BIAS    = 132;
    localparam int unsigned MAG_MAX    = 32767;

    // Clip limit never exceeds the largest 15-bit magnitude.
    localparam logic [14:0] CLIP_LIM =
        15'((CLIP_LEVEL > MAG_MAX) ? MAG_MAX : CLIP_LEVEL);
    localparam logic [15:0] MU_BIAS_W  = 16'(MU_BIAS);
    localparam logic [15:0] MAG_MAX_W  = 16'(MAG_MAX);

    localparam logic [7:0]  STD_MU_BIAS = 8'd132;
    localparam logic [7:0]  A_XOR       = 8'h55;
    localparam logic [7:0]  SIGN_BIT    = 8'h80;
    localparam logic [14:0] A_LIN_LIMIT = 15'd256;
    localparam logic [8:0]  A_SEG0_ADD  = 9'h008;
    localparam logic [8:0]  A_SEGN_ADD  = 9'h108;

    localparam logic LAW_MU   = 1'b0;
    localparam logic LAW_ALAW = 1'b1;

    // Register index as decoded from paddr[2].
    localparam logic REG_LAW_SELECT = 1'b0;

    // Load enables of the three pipeline stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } adv_t;

    // Position of the highest set bit; zero for a zero input.
    function automatic logic [2:0] lead_one8(input logic [7:0] v);
        logic [2:0] pos;
        pos = 3'd0;
        for (int i = 1; i < 8; i++) begin
            if (v[i]) begin
                pos = 3'(i);
            end
        end
        return pos;
    endfunction

endpackage

// File: hw/rtl/g711_compander_round_trip_top.sv
// Top level of the G.711 mu-law / A-law round trip: handshakes, config register, pipeline.
// Depends on g711rt_pkg, g711rt_datapath and assert_macros.svh.
//
//   channel | direction | handshake        | payload
//   s_      | in        | s_valid/s_ready  | s_pcm_sample (signed 16)
//   m_      | out       | m_valid/m_ready  | m_code_byte (8), m_expanded_sample (signed 16)
//   APB     | in/out    | psel/penable     | law_select at byte address 0
//
// An accepted beat moves through stage 1 and stage 2 into the output register before it
// can leave. The three-stage pipeline takes a new beat every cycle unless full and stalled.
// Reset is synchronous and active low; it clears the stage valid bits and law_select.
// A stall at the output holds the last stage; earlier stages keep filling their empty slots,
// so s_ready drops only once every stage holds a beat.
module g711_compander_round_trip_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_pcm_sample,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_code_byte,
    output logic signed [15:0] m_expanded_sample,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    `include "assert_macros.svh"

    // The only register is law_select; writes to other addresses are dropped.
    logic law_select_reg;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[2] == g711rt_pkg::REG_LAW_SELECT);
    assign prdata    = (paddr[2] == g711rt_pkg::REG_LAW_SELECT)
                     ? {31'd0, law_select_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            law_select_reg <= g711rt_pkg::LAW_MU;
        end else if (cfg_write) begin
            law_select_reg <= pwdata[0];
        end
    end

    // Valid bits travel with the beats. A stage loads when it is empty or its
    // contents move on in the same cycle, so bubbles collapse during a stall.
    logic v1_reg, v2_reg, v3_reg;
    g711rt_pkg::adv_t adv;

    always_comb begin
        adv.s3 = !v3_reg || m_ready;
        adv.s2 = !v2_reg || adv.s3;
        adv.s1 = !v1_reg || adv.s2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv.s1) begin
                v1_reg <= s_valid;
            end
            if (adv.s2) begin
                v2_reg <= v1_reg;
            end
            if (adv.s3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    assign s_ready = adv.s1;
    assign m_valid = v3_reg;

    g711rt_datapath u_datapath (
        .aclk            (aclk),
        .adv             (adv),
        .law_select      (law_select_reg),
        .pcm_sample      (s_pcm_sample),
        .code_byte       (m_code_byte),
        .expanded_sample (m_expanded_sample)
    );

    // Every stage holds a beat.
    logic pipe_full;
    assign pipe_full = v1_reg && v2_reg && v3_reg;

    // An empty output stage means the pipeline can always take a beat.
    `ASSERT_IMPL(a_empty_ready, aclk, aresetn, !m_valid, s_ready, "s_ready low with output empty")

    // An accepted beat always lands in the first stage.
    `ASSERT_NEXT(a_accept_s1, aclk, aresetn, s_valid && s_ready, v1_reg, "beat lost at stage 1")

    // With every stage full and the output stalled, nothing more may enter.
    `ASSERT_IMPL(a_full_stall, aclk, aresetn, pipe_full && !m_ready, !s_ready, "taken while full")

endmodule

// File: hw/rtl/g711rt_datapath.sv
// Three-stage payload path of the G.711 round trip: magnitude, encode, decode.
// Depends on g711rt_pkg; stage load enables come from the top level.
module g711rt_datapath (
    input  logic                aclk,
    input  g711rt_pkg::adv_t    adv,
    input  logic                law_select,
    input  logic signed [15:0]  pcm_sample,
    output logic [7:0]          code_byte,
    output logic signed [15:0]  expanded_sample
);

    // Stage 1: sign, clipped magnitude, bias for mu-law.
    logic        neg1_reg, law1_reg;
    logic [14:0] mag1_reg;
    logic [14:0] mag1_next;
    logic [16:0] mag_abs;
    logic [14:0] mag_clip;
    logic [15:0] mag_bias;

    always_comb begin
        mag_abs  = pcm_sample[15] ? (17'h10000 - {1'b0, pcm_sample})
                                  : {1'b0, pcm_sample};
        mag_clip = (mag_abs > {2'b00, g711rt_pkg::CLIP_LIM}) ? g711rt_pkg::CLIP_LIM
                                                             : mag_abs[14:0];
        mag_bias = {1'b0, mag_clip} + g711rt_pkg::MU_BIAS_W;
        if (mag_bias > g711rt_pkg::MAG_MAX_W) begin
            mag_bias = g711rt_pkg::MAG_MAX_W;
        end
        mag1_next = (law_select == g711rt_pkg::LAW_ALAW) ? mag_clip : mag_bias[14:0];
    end

    always_ff @(posedge aclk) begin
        if (adv.s1) begin
            neg1_reg <= pcm_sample[15];
            law1_reg <= law_select;
            mag1_reg <= mag1_next;
        end
    end

    // Stage 2: segment from the leading one, mantissa, code byte.
    logic       law2_reg;
    logic [7:0] code2_reg;
    logic [7:0] code2_next;
    logic [2:0] mu_e, a_e;
    logic [14:0] mu_sh, a_sh;
    logic [7:0] mu_code, a_c, a_sign;

    always_comb begin
        mu_e    = g711rt_pkg::lead_one8(mag1_reg[14:7]);
        mu_sh   = mag1_reg >> ({1'b0, mu_e} + 4'd3);
        mu_code = ~{neg1_reg, mu_e, mu_sh[3:0]};
        a_e     = 3'd1 + g711rt_pkg::lead_one8({1'b0, mag1_reg[14:8]});
        a_sh    = mag1_reg >> ({1'b0, a_e} + 4'd3);
        a_c     = (mag1_reg >= g711rt_pkg::A_LIN_LIMIT) ? {1'b0, a_e, a_sh[3:0]}
                                                         : {4'b0000, mag1_reg[7:4]};
        a_sign  = neg1_reg ? 8'h00 : g711rt_pkg::SIGN_BIT;
        code2_next = (law1_reg == g711rt_pkg::LAW_ALAW)
                   ? (a_c ^ a_sign ^ g711rt_pkg::A_XOR) : mu_code;
    end

    always_ff @(posedge aclk) begin
        if (adv.s2) begin
            law2_reg  <= law1_reg;
            code2_reg <= code2_next;
        end
    end

    // Stage 3: standard G.711 expansion of the code.
    logic [7:0]  code3_reg;
    logic [15:0] lin3_reg;
    logic [15:0] lin3_next;
    logic [7:0]  mu_u, a_a;
    logic [7:0]  mu_t0;
    logic [14:0] mu_t;
    logic [8:0]  a_base;
    logic [14:0] a_t;
    logic [15:0] mu_lin, a_lin;

    always_comb begin
        mu_u   = ~code2_reg;
        mu_t0  = {1'b0, mu_u[3:0], 3'b000} + g711rt_pkg::STD_MU_BIAS;
        mu_t   = {7'd0, mu_t0} << mu_u[6:4];
        mu_lin = mu_u[7] ? ({8'd0, g711rt_pkg::STD_MU_BIAS} - {1'b0, mu_t})
                         : ({1'b0, mu_t} - {8'd0, g711rt_pkg::STD_MU_BIAS});
        a_a    = code2_reg ^ g711rt_pkg::A_XOR;
        a_base = {1'b0, a_a[3:0], 4'b0000};
        if (a_a[6:4] == 3'd0) begin
            a_t = {6'd0, a_base + g711rt_pkg::A_SEG0_ADD};
        end else begin
            a_t = {6'd0, a_base + g711rt_pkg::A_SEGN_ADD} << (a_a[6:4] - 3'd1);
        end
        a_lin  = a_a[7] ? {1'b0, a_t} : (16'd0 - {1'b0, a_t});
        lin3_next = (law2_reg == g711rt_pkg::LAW_ALAW) ? a_lin : mu_lin;
    end

    always_ff @(posedge aclk) begin
        if (adv.s3) begin
            code3_reg <= code2_reg;
            lin3_reg  <= lin3_next;
        end
    end

    assign code_byte       = code3_reg;
    assign expanded_sample = lin3_reg;

endmodule

// File: tb/sv/g711_compander_round_trip_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the G.711 mu-law / A-law round-trip block.
// Depends on g711rt_pkg and g711_compander_round_trip_top; it predicts each code and
// expanded sample itself and checks every result beat in order of arrival.
module g711_compander_round_trip_top_tb;

    // Compander constants of the standard, kept here apart from the RTL package.
    localparam int unsigned CLIP_LEVEL  = 32635;
    localparam int unsigned MU_BIAS     = 132;
    localparam int unsigned STD_MU_BIAS = 132;
    localparam int unsigned MAG_MAX     = 32767;

    // Register map: law_select sits at byte address 0. Address 4 decodes to a register
    // index that does not exist, so a write there must leave law_select alone.
    localparam logic [2:0] ADDR_LAW_SELECT = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED   = 3'd4;

    // Quiet cycles tolerated before the run is declared hung. The longest legal quiet
    // stretch is a few register writes plus a drain, far below this.
    localparam int unsigned HANG_LIMIT = 2000;
    // Cycles allowed after the last result for any stray beat to show up.
    localparam int unsigned SETTLE_CYCLES = 8;

    typedef struct {
        logic [7:0]         code;
        logic signed [15:0] pcm;
    } codec_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_pcm_sample = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [7:0]         m_code_byte;
    logic signed [15:0] m_expanded_sample;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    g711_compander_round_trip_top dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_pcm_sample      (s_pcm_sample),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_code_byte       (m_code_byte),
        .m_expanded_sample (m_expanded_sample),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Testbench copy of the configuration, updated by every register write it issues to law_select.
    logic law_sel = g711rt_pkg::LAW_MU;

    logic [15:0]   samples_to_send[$];
    codec_result_t pending_results[$];
    int unsigned   samples_queued = 0;
    int unsigned   samples_taken = 0;
    int unsigned   mismatches = 0;

    // Pacing switches; the stimulus turns them off to get stretches with no idling.
    logic s_pace_on = 1'b1;
    logic m_pace_on = 1'b1;

    // Flags recorded at the rising edge so the falling-edge drivers know a beat moved.
    logic sample_taken = 1'b0;
    logic result_taken = 1'b0;
    int unsigned s_gap = 0;
    int unsigned m_stall = 0;
    int unsigned quiet_cycles = 0;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // floor(log2(v)), with zero for an input of zero or one.
    function automatic int unsigned msb_index(input int unsigned v);
        int unsigned n;
        n = 0;
        while (v > 1) begin
            v = v >> 1;
            n++;
        end
        return n;
    endfunction

    // Magnitude of a two's complement sample, clipped to the compander limit.
    // The most negative sample has magnitude 32768 and simply clips.
    function automatic int unsigned clipped_magnitude(input logic [15:0] raw);
        int unsigned mag;
        int unsigned lim;
        mag = raw[15] ? (32'h10000 - 32'(raw)) : 32'(raw);
        lim = (CLIP_LEVEL > MAG_MAX) ? MAG_MAX : CLIP_LEVEL;
        return (mag > lim) ? lim : mag;
    endfunction

    function automatic logic [7:0] mu_compress(input logic [15:0] raw);
        int unsigned mag;
        int unsigned seg;
        int unsigned mant;
        int unsigned sgn;
        sgn = raw[15] ? 32'h80 : 32'h0;
        // The biased magnitude saturates at the 15-bit ceiling.
        mag = clipped_magnitude(raw) + MU_BIAS;
        if (mag > MAG_MAX) begin
            mag = MAG_MAX;
        end
        seg  = msb_index((mag >> 7) & 32'hff);
        mant = (mag >> (seg + 3)) & 32'h0f;
        return ~8'(sgn | (seg << 4) | mant);
    endfunction

    // Expansion always uses the standard bias, regardless of the encode bias.
    function automatic logic signed [15:0] mu_expand(input logic [7:0] code);
        logic [7:0] u;
        int         t;
        u = ~code;
        t = (int'(u[3:0]) << 3) + int'(STD_MU_BIAS);
        t = t << u[6:4];
        return u[7] ? 16'(int'(STD_MU_BIAS) - t) : 16'(t - int'(STD_MU_BIAS));
    endfunction

    function automatic logic [7:0] a_compress(input logic [15:0] raw);
        int unsigned mag;
        int unsigned seg;
        int unsigned mant;
        int unsigned c;
        int unsigned sgn;
        // A-law sets the sign bit for non-negative samples.
        sgn = raw[15] ? 32'h0 : 32'h80;
        mag = clipped_magnitude(raw);
        if (mag >= 256) begin
            seg  = 1 + msb_index((mag >> 8) & 32'h7f);
            mant = (mag >> (seg + 3)) & 32'h0f;
            c    = (seg << 4) | mant;
        end else begin
            c = mag >> 4;
        end
        return 8'(c ^ sgn ^ 32'h55);
    endfunction

    function automatic logic signed [15:0] a_expand(input logic [7:0] code);
        logic [7:0] a;
        int         t;
        a = code ^ 8'h55;
        t = int'(a[3:0]) << 4;
        if (a[6:4] == 3'd0) begin
            t = t + 8;
        end else begin
            t = t + 'h108;
            if (a[6:4] > 3'd1) begin
                t = t << (a[6:4] - 3'd1);
            end
        end
        return a[7] ? 16'(t) : 16'(-t);
    endfunction

    function automatic codec_result_t predict_round_trip(input logic law,
                                                         input logic [15:0] raw);
        codec_result_t r;
        if (law == g711rt_pkg::LAW_ALAW) begin
            r.code = a_compress(raw);
            r.pcm  = a_expand(r.code);
        end else begin
            r.code = mu_compress(raw);
            r.pcm  = mu_expand(r.code);
        end
        return r;
    endfunction

    task automatic log_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Input side: the driver presents samples at the falling edge; the rising-edge
    // block below sees each accepted beat and files its prediction.
    // ------------------------------------------------------------------------

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_gap   <= 0;
        end else if (!s_valid || sample_taken) begin
            // The channel is free: either idle out the drawn gap or present the next
            // sample. Keeping s_valid high here lets back-to-back beats flow.
            if (s_gap != 0) begin
                s_valid <= 1'b0;
                s_gap   <= s_gap - 1;
            end else if (samples_to_send.size() != 0) begin
                s_pcm_sample <= samples_to_send.pop_front();
                s_valid      <= 1'b1;
                s_gap        <= s_pace_on ? $urandom_range(0, 9) : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            sample_taken <= 1'b0;
        end else begin
            sample_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                pending_results.push_back(predict_round_trip(law_sel, s_pcm_sample));
                samples_taken <= samples_taken + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output side: m_ready drops for a drawn number of cycles after each result beat,
    // and every result beat is checked against the oldest prediction.
    // ------------------------------------------------------------------------

    always @(negedge aclk) begin : ready_pacer
        int unsigned hold;
        if (!aresetn) begin
            m_ready <= 1'b0;
            m_stall <= 0;
        end else if (m_ready && result_taken) begin
            hold    = m_pace_on ? $urandom_range(0, 9) : 0;
            m_ready <= (hold == 0);
            m_stall <= (hold == 0) ? 0 : hold - 1;
        end else if (!m_ready) begin
            if (m_stall == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_stall <= m_stall - 1;
            end
        end
    end

    always @(posedge aclk) begin : result_checker
        codec_result_t want;
        if (!aresetn) begin
            result_taken <= 1'b0;
        end else begin
            result_taken <= m_valid && m_ready;
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    log_mismatch($sformatf("result beat with nothing pending: code %02h pcm %0d",
                                           m_code_byte, m_expanded_sample));
                end else begin
                    want = pending_results.pop_front();
                    if (m_code_byte !== want.code) begin
                        log_mismatch($sformatf("code_byte got %02h, predicted %02h",
                                               m_code_byte, want.code));
                    end
                    if (m_expanded_sample !== want.pcm) begin
                        log_mismatch($sformatf("expanded_sample got %0d, predicted %0d",
                                               m_expanded_sample, want.pcm));
                    end
                end
            end
        end
    end

    // Watchdog: any accepted beat on either channel counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Register write: a setup phase, then an access phase held until pready.
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        // Only the low bit of law_select is stored; other addresses are ignored.
        if (addr == ADDR_LAW_SELECT) begin
            law_sel = data[0];
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic queue_sample(input logic [15:0] raw);
        samples_to_send.push_back(raw);
        samples_queued++;
    endtask

    // Hold off until every queued sample went in and every result came out, then let
    // the settle time pass so the three-stage pipeline and the block are truly idle.
    task automatic wait_for_drain();
        while (samples_taken != samples_queued || pending_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Random samples mix full-range values with the regions where the laws change
    // behavior: tiny magnitudes, segment edges and the clip region.
    function automatic logic [15:0] draw_sample();
        int v;
        case ($urandom_range(0, 3))
            0: v = int'($urandom_range(0, 65535));
            1: v = int'($urandom_range(0, 600));
            2: v = int'($urandom_range(32500, 32767));
            default: v = (1 << $urandom_range(4, 14)) + int'($urandom_range(0, 8)) - 4;
        endcase
        if ($urandom_range(0, 1) == 1) begin
            v = -v;
        end
        return 16'(v);
    endfunction

    task automatic queue_random(input int unsigned count);
        repeat (count) queue_sample(draw_sample());
    endtask

    // Directed samples: zero, the smallest magnitudes, both rails, the clip edges,
    // the mu-law point where the bias first reaches segment one, the A-law linear
    // segment edge, and alternating bit patterns.
    task automatic queue_directed();
        queue_sample(16'sd0);
        queue_sample(16'sd1);
        queue_sample(-16'sd1);
        queue_sample(16'sd32767);
        queue_sample(16'h8000);
        queue_sample(16'sd32635);
        queue_sample(-16'sd32636);
        queue_sample(16'sd124);
        queue_sample(16'sd255);
        queue_sample(-16'sd256);
        queue_sample(16'h5555);
        queue_sample(16'haaaa);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Mu-law straight out of reset, with the register never written.
        queue_directed();
        wait_for_drain();

        // Switch to A-law with all data bits set; only bit 0 may be kept.
        reg_write(ADDR_LAW_SELECT, 32'hffff_ffff);
        queue_directed();
        wait_for_drain();

        // A write to an unmapped address must not disturb A-law. Both sides run flat out.
        reg_write(ADDR_UNMAPPED, 32'h0000_0000);
        s_pace_on = 1'b0;
        m_pace_on = 1'b0;
        queue_random(100);
        wait_for_drain();

        // Back to mu-law with the upper bits set and bit 0 clear; sender paced only.
        reg_write(ADDR_LAW_SELECT, 32'hffff_fffe);
        s_pace_on = 1'b1;
        queue_random(100);
        wait_for_drain();

        // A-law with both sides idling. Halfway through, the sender holds off until
        // the pipeline has emptied before it resumes.
        reg_write(ADDR_LAW_SELECT, 32'h0000_0001);
        m_pace_on = 1'b1;
        queue_random(50);
        wait_for_drain();
        queue_random(50);
        wait_for_drain();

        // Mu-law again, receiver stalling against a sender with no gaps.
        reg_write(ADDR_LAW_SELECT, 32'h0000_0000);
        s_pace_on = 1'b0;
        queue_random(100);
        wait_for_drain();

        if (pending_results.size() != 0) begin
            log_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
